/* sv/twdcc_pkg.sv */
`default_nettype none
package twdcc_pkg;

  localparam int SETS_DEF      = 256;
  localparam int WAY_WORDS_DEF = 2048;

  localparam int ADDR_W   = 28;
  localparam int DATA_W   = 32;
  localparam int MASK_W   = 4;
  localparam int TAG_W    = 15;
  localparam int TAG_LSB  = 13;
  localparam int LINE_LSB = 5;
  localparam int WORD_LSB = 2;

  typedef struct packed {
    logic clear;
    logic accept;
    logic merge;
    logic wb_step;
    logic fill_step;
    logic look;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } stat_t;

  function automatic logic [DATA_W-1:0] merge_bytes(input logic [DATA_W-1:0] old_word,
                                                     input logic [DATA_W-1:0] new_word,
                                                     input logic [MASK_W-1:0] mask);
    logic [DATA_W-1:0] res;
    res = old_word;
    for (int k = 0; k < MASK_W; k++) begin
      if (mask[k]) begin
        res[8*k +: 8] = new_word[8*k +: 8];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* sv/twdcc_ctrl.sv */
`default_nettype none
module twdcc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  twdcc_pkg::stat_t       stat,
  output twdcc_pkg::cmd_t        cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MERGE,
    ST_WBRD,
    ST_FILL,
    ST_LOOK,
    ST_FIN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR: if (stat.clear_last) state <= ST_IDLE;
        ST_IDLE:  if (in_valid) state <= ST_MERGE;
        ST_MERGE: state <= ST_WBRD;
        ST_WBRD:  state <= ST_FILL;
        ST_FILL:  state <= ST_LOOK;
        ST_LOOK:  state <= ST_FIN;
        ST_FIN:   if (stat.out_free) state <= ST_IDLE;
        default:  state <= ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_CLEAR: cmd.clear     = 1'b1;
      ST_IDLE:  cmd.accept    = in_valid;
      ST_MERGE: cmd.merge     = 1'b1;
      ST_WBRD:  cmd.wb_step   = 1'b1;
      ST_FILL:  cmd.fill_step = 1'b1;
      ST_LOOK:  cmd.look      = 1'b1;
      ST_FIN:   cmd.finish    = stat.out_free;
      default:  cmd = '0;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

endmodule
`default_nettype wire

/* sv/twdcc_dp.sv */
`default_nettype none
module twdcc_dp #(
  parameter int SETS      = twdcc_pkg::SETS_DEF,
  parameter int WAY_WORDS = twdcc_pkg::WAY_WORDS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  twdcc_pkg::cmd_t                        cmd,
  output twdcc_pkg::stat_t                       stat,
  input  wire logic [twdcc_pkg::ADDR_W-1:0]      cpu_addr,
  input  wire logic                              cpu_read,
  input  wire logic [twdcc_pkg::MASK_W-1:0]      cpu_byte_mask,
  input  wire logic [twdcc_pkg::DATA_W-1:0]      cpu_write_data,
  input  wire logic [twdcc_pkg::ADDR_W-1:0]      bus_addr,
  input  wire logic                              bus_fill_ack,
  input  wire logic                              bus_writeback_ack,
  input  wire logic                              bus_read_strobe,
  input  wire logic                              bus_write_strobe,
  input  wire logic                              bus_last_beat,
  input  wire logic [twdcc_pkg::DATA_W-1:0]      bus_fill_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [twdcc_pkg::DATA_W-1:0]           cpu_read_data,
  output logic                                   cpu_ready,
  output logic                                   fill_active,
  output logic [twdcc_pkg::ADDR_W-1:0]           fill_addr,
  output logic [twdcc_pkg::ADDR_W-1:0]           writeback_addr,
  output logic [twdcc_pkg::DATA_W-1:0]           writeback_data,
  output logic                                   fill_request,
  output logic                                   writeback_request
);

  localparam int SIDX = $clog2(SETS);
  localparam int WIDX = $clog2(WAY_WORDS);
  localparam int AW   = twdcc_pkg::ADDR_W;
  localparam int DW   = twdcc_pkg::DATA_W;
  localparam int TW   = twdcc_pkg::TAG_W;
  localparam int MW   = twdcc_pkg::MASK_W;

  // captured item
  logic [AW-1:0] c_ca, c_ba;
  logic          c_rd, c_fack, c_wack, c_rstb, c_wstb, c_last;
  logic [MW-1:0] c_bm;
  logic [DW-1:0] c_cwd, c_fdat;

  // line data and tag stores
  logic [DW-1:0] mem0 [WAY_WORDS];
  logic [DW-1:0] mem1 [WAY_WORDS];
  logic [TW-1:0] tmem0 [SETS];
  logic [TW-1:0] tmem1 [SETS];
  logic [DW-1:0] rd0, rd1;
  logic [TW-1:0] tr0, tr1;
  logic [SETS-1:0] v0, v1, lru;

  // held lookup
  logic [DW-1:0] hw0, hw1;
  logic [TW-1:0] ht0, ht1;
  logic          hv0, hv1, hlast;

  // pending write and control flags
  logic [AW-1:0] pend_addr;
  logic [DW-1:0] pend_data;
  logic [MW-1:0] pend_mask;
  logic fill_done, wb_lock, wb_done, fill_way, wb_way, wb_armed;
  logic wb_running, hit0, hit1, fill_req, fill_running;
  logic [AW-1:0] wb_line_addr;
  logic [DW-1:0] wdata;
  logic          wb_take, look;
  logic [WIDX-1:0] clr_addr;

  // result register
  logic [DW-1:0] o_rdata, o_wdata;
  logic [AW-1:0] o_faddr, o_waddr;
  logic          o_ready, o_factive, o_freq, o_wreq;

  logic [WIDX-1:0] pw, bw, cw, mem_addr;
  logic [SIDX-1:0] ps, bs, cs, tag_addr;
  logic [TW-1:0]   ct, bt;
  logic            we0, we1, twe0, twe1;
  logic [DW-1:0]   wd0, wd1;
  logic            merge_en, fill_branch, fill_end;
  logic            hit0_n, hit1_n, hit_n, access, busy_fill, busy_wb, ready_n, freq_n;
  logic [DW-1:0]   rdata_n;

  assign pw = pend_addr[twdcc_pkg::WORD_LSB +: WIDX];
  assign ps = pend_addr[twdcc_pkg::LINE_LSB +: SIDX];
  assign bw = c_ba[twdcc_pkg::WORD_LSB +: WIDX];
  assign bs = c_ba[twdcc_pkg::LINE_LSB +: SIDX];
  assign cw = c_ca[twdcc_pkg::WORD_LSB +: WIDX];
  assign cs = c_ca[twdcc_pkg::LINE_LSB +: SIDX];
  assign ct = c_ca[twdcc_pkg::TAG_LSB +: TW];
  assign bt = c_ba[twdcc_pkg::TAG_LSB +: TW];

  assign merge_en    = (pend_mask != '0) && (hit0 || hit1);
  assign fill_branch = !fill_req && fill_running;
  assign fill_end    = fill_branch && c_last;

  assign stat.clear_last = (clr_addr == {WIDX{1'b1}});
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      c_ca   <= cpu_addr;
      c_rd   <= cpu_read;
      c_bm   <= cpu_byte_mask;
      c_cwd  <= cpu_write_data;
      c_ba   <= bus_addr;
      c_fack <= bus_fill_ack;
      c_wack <= bus_writeback_ack;
      c_rstb <= bus_read_strobe;
      c_wstb <= bus_write_strobe;
      c_last <= bus_last_beat;
      c_fdat <= bus_fill_data;
    end
  end

  always_comb begin
    mem_addr = pw;
    we0 = 1'b0;
    we1 = 1'b0;
    wd0 = '0;
    wd1 = '0;
    if (cmd.clear) begin
      mem_addr = clr_addr;
      we0 = 1'b1;
      we1 = 1'b1;
    end else if (cmd.merge) begin
      mem_addr = pw;
      we0 = merge_en && hit0;
      we1 = merge_en && hit1;
      wd0 = twdcc_pkg::merge_bytes(rd0, pend_data, pend_mask);
      wd1 = twdcc_pkg::merge_bytes(rd1, pend_data, pend_mask);
    end else if (cmd.wb_step) begin
      mem_addr = bw;
    end else if (cmd.fill_step) begin
      mem_addr = fill_branch ? bw : cw;
      we0 = fill_branch && c_wstb && !fill_way;
      we1 = fill_branch && c_wstb && fill_way;
      wd0 = c_fdat;
      wd1 = c_fdat;
    end
  end

  always_ff @(posedge clk) begin
    if (we0) mem0[mem_addr] <= wd0;
    rd0 <= mem0[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (we1) mem1[mem_addr] <= wd1;
    rd1 <= mem1[mem_addr];
  end

  assign tag_addr = (cmd.fill_step && fill_branch) ? bs : cs;
  assign twe0     = cmd.fill_step && fill_end && !fill_way;
  assign twe1     = cmd.fill_step && fill_end && fill_way;

  always_ff @(posedge clk) begin
    if (twe0) tmem0[tag_addr] <= bt;
    if (twe1) tmem1[tag_addr] <= bt;
    tr0 <= tmem0[tag_addr];
    tr1 <= tmem1[tag_addr];
  end

  assign hit0_n  = hv0 && (ht0 == ct);
  assign hit1_n  = hv1 && (ht1 == ct);
  assign hit_n   = hit0_n || hit1_n;
  assign rdata_n = hit0_n ? hw0 : (hit1_n ? hw1 : '0);
  assign access    = c_rd || (c_bm != '0);
  assign busy_fill = !hit_n || fill_running || fill_done;
  assign busy_wb   = wb_lock && !wb_done;
  assign ready_n   = !(busy_fill || busy_wb) || !access;
  assign freq_n    = access && !hit_n && !fill_running;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= '0; v1 <= '0; lru <= '0;
      hw0 <= '0; hw1 <= '0; ht0 <= '0; ht1 <= '0;
      hv0 <= 1'b0; hv1 <= 1'b0; hlast <= 1'b0;
      pend_addr <= '0; pend_data <= '0; pend_mask <= '0;
      fill_done <= 1'b0; wb_lock <= 1'b0; wb_done <= 1'b0; fill_way <= 1'b0;
      wb_way <= 1'b0; wb_armed <= 1'b0; wb_running <= 1'b0; hit0 <= 1'b0;
      hit1 <= 1'b0; fill_req <= 1'b0; fill_running <= 1'b0;
      wb_line_addr <= '0; wdata <= '0; wb_take <= 1'b0; look <= 1'b0;
      clr_addr <= '0; out_valid <= 1'b0;
      o_rdata <= '0; o_wdata <= '0; o_faddr <= '0; o_waddr <= '0;
      o_ready <= 1'b0; o_factive <= 1'b0; o_freq <= 1'b0; o_wreq <= 1'b0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;

      // byte merge of last item's write, way 1 wins when both hit
      if (cmd.merge) begin
        wb_done <= 1'b0;
        if (merge_en) begin
          wb_armed     <= 1'b1;
          wb_line_addr <= pend_addr;
          lru[ps]      <= hit1;
          wb_way       <= hit1;
        end
      end

      // write-back handshake
      if (cmd.wb_step) begin
        wb_take <= !wb_armed && wb_running && c_rstb;
        if (wb_armed) begin
          wb_lock <= 1'b1;
          if (c_wack) begin
            wb_running <= 1'b1;
            wb_armed   <= 1'b0;
          end
        end else if (wb_running && c_last) begin
          lru[bs]    <= wb_way;
          wb_running <= 1'b0;
          fill_done  <= 1'b1;
          wb_lock    <= 1'b0;
          wb_done    <= 1'b1;
        end
      end

      // fill handshake or set lookup
      if (cmd.fill_step) begin
        if (wb_take) wdata <= wb_way ? rd1 : rd0;
        look <= 1'b0;
        if (fill_req) begin
          if (c_fack) fill_running <= 1'b1;
          fill_way <= !hlast;
        end else if (fill_running) begin
          if (c_last) begin
            fill_running <= 1'b0;
            fill_done    <= 1'b1;
            lru[bs]      <= fill_way;
            if (fill_way) begin
              v1[bs] <= 1'b1;
              ht1    <= bt;
              hv1    <= 1'b1;
            end else begin
              v0[bs] <= 1'b1;
              ht0    <= bt;
              hv0    <= 1'b1;
            end
          end
        end else begin
          fill_done <= 1'b0;
          look      <= 1'b1;
          hv0       <= v0[cs];
          hv1       <= v1[cs];
          hlast     <= lru[cs];
        end
      end

      if (cmd.look && look) begin
        hw0 <= rd0;
        hw1 <= rd1;
        ht0 <= tr0;
        ht1 <= tr1;
      end

      if (cmd.finish) begin
        pend_addr <= c_ca;
        pend_data <= c_cwd;
        pend_mask <= ((pend_mask != '0) || wb_lock) ? '0 : c_bm;
        hit0      <= hit0_n;
        hit1      <= hit1_n;
        fill_req  <= freq_n;
        o_rdata   <= rdata_n;
        o_ready   <= ready_n;
        o_factive <= fill_running;
        o_faddr   <= {c_ca[AW-1:twdcc_pkg::LINE_LSB], {twdcc_pkg::LINE_LSB{1'b0}}};
        o_waddr   <= wb_line_addr;
        o_wdata   <= wdata;
        o_freq    <= freq_n;
        o_wreq    <= wb_armed && !wb_running;
      end

      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cpu_read_data     = o_rdata;
  assign cpu_ready         = o_ready;
  assign fill_active       = o_factive;
  assign fill_addr         = o_faddr;
  assign writeback_addr    = o_waddr;
  assign writeback_data    = o_wdata;
  assign fill_request      = o_freq;
  assign writeback_request = o_wreq;

  a_arm_run_excl: assert property (@(posedge clk) disable iff (rst)
    !(wb_armed && wb_running))
    else $error("write-back armed while running");

  a_run_locked: assert property (@(posedge clk) disable iff (rst)
    wb_running |-> wb_lock)
    else $error("write-back running without lock");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished item not presented");

endmodule
`default_nettype wire

/* sv/two_way_data_cache_controller_core.sv */
`default_nettype none
// Two-way set-associative data cache controller with per-set last-used tracking.
// Each input item is one cycle of CPU and bus port values and yields one result
// item. An item passes through these steps in order: merge read in the cycle it is accepted,
// then merge write, write-back read, fill write or lookup read, lookup capture and
// finish, all set by the single shared port of the line data memories. The result
// is registered after the finish step, and no new item is accepted until that step is
// done. A stalled result holds the finish step of the following item until the output
// register is free. After reset a clearing pass zeroes every word of the data
// memories, during which no item is accepted.
module two_way_data_cache_controller_core #(
  parameter int SETS      = twdcc_pkg::SETS_DEF,
  parameter int WAY_WORDS = twdcc_pkg::WAY_WORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [twdcc_pkg::ADDR_W-1:0]  cpu_addr,
  input  wire logic                          cpu_read,
  input  wire logic [twdcc_pkg::MASK_W-1:0]  cpu_byte_mask,
  input  wire logic [twdcc_pkg::DATA_W-1:0]  cpu_write_data,
  input  wire logic [twdcc_pkg::ADDR_W-1:0]  bus_addr,
  input  wire logic                          bus_fill_ack,
  input  wire logic                          bus_writeback_ack,
  input  wire logic                          bus_read_strobe,
  input  wire logic                          bus_write_strobe,
  input  wire logic                          bus_last_beat,
  input  wire logic [twdcc_pkg::DATA_W-1:0]  bus_fill_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [twdcc_pkg::DATA_W-1:0]       cpu_read_data,
  output logic                               cpu_ready,
  output logic                               fill_active,
  output logic [twdcc_pkg::ADDR_W-1:0]       fill_addr,
  output logic [twdcc_pkg::ADDR_W-1:0]       writeback_addr,
  output logic [twdcc_pkg::DATA_W-1:0]       writeback_data,
  output logic                               fill_request,
  output logic                               writeback_request
);

  twdcc_pkg::cmd_t  cmd;
  twdcc_pkg::stat_t stat;

  twdcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  twdcc_dp #(
    .SETS      (SETS),
    .WAY_WORDS (WAY_WORDS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cpu_addr          (cpu_addr),
    .cpu_read          (cpu_read),
    .cpu_byte_mask     (cpu_byte_mask),
    .cpu_write_data    (cpu_write_data),
    .bus_addr          (bus_addr),
    .bus_fill_ack      (bus_fill_ack),
    .bus_writeback_ack (bus_writeback_ack),
    .bus_read_strobe   (bus_read_strobe),
    .bus_write_strobe  (bus_write_strobe),
    .bus_last_beat     (bus_last_beat),
    .bus_fill_data     (bus_fill_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .cpu_read_data     (cpu_read_data),
    .cpu_ready         (cpu_ready),
    .fill_active       (fill_active),
    .fill_addr         (fill_addr),
    .writeback_addr    (writeback_addr),
    .writeback_data    (writeback_data),
    .fill_request      (fill_request),
    .writeback_request (writeback_request)
  );

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int ADDR_W = twdcc_pkg::ADDR_W;
  localparam int DATA_W = twdcc_pkg::DATA_W;
  localparam int MASK_W = twdcc_pkg::MASK_W;
  localparam int TAG_W  = twdcc_pkg::TAG_W;
  localparam int NSETS = twdcc_pkg::SETS_DEF;
  localparam int NWORDS = twdcc_pkg::WAY_WORDS_DEF;
  localparam int N_RANDOM = 800;

  typedef struct {
    logic [ADDR_W-1:0] ca;
    logic              rd;
    logic [MASK_W-1:0] bm;
    logic [DATA_W-1:0] wd;
    logic [ADDR_W-1:0] ba;
    logic              fack, wack, rstb, wstb, last;
    logic [DATA_W-1:0] fd;
  } cyc_t;

  typedef struct {
    logic [DATA_W-1:0] rdata;
    logic              ready, fact;
    logic [ADDR_W-1:0] faddr, wbaddr;
    logic [DATA_W-1:0] wbdata;
    logic              freq, wbreq;
  } port_vals_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic [ADDR_W-1:0] cpu_addr = '0, bus_addr = '0;
  logic cpu_read = 0, bus_fill_ack = 0, bus_writeback_ack = 0;
  logic bus_read_strobe = 0, bus_write_strobe = 0, bus_last_beat = 0;
  logic [MASK_W-1:0] cpu_byte_mask = '0;
  logic [DATA_W-1:0] cpu_write_data = '0, bus_fill_data = '0;
  logic [DATA_W-1:0] cpu_read_data, writeback_data;
  logic cpu_ready, fill_active, fill_request, writeback_request;
  logic [ADDR_W-1:0] fill_addr, writeback_addr;

  two_way_data_cache_controller_core dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // cache mirror
  logic [DATA_W-1:0] w0_data [NWORDS], w1_data [NWORDS];
  logic [TAG_W-1:0]  w0_tag [NSETS], w1_tag [NSETS];
  logic              w0_vld [NSETS], w1_vld [NSETS], lru [NSETS];
  logic [DATA_W-1:0] held_word [2];
  logic [TAG_W-1:0]  held_tag [2];
  logic              held_vld [2];
  logic              held_last;
  logic [ADDR_W-1:0] pend_addr, wb_line;
  logic [DATA_W-1:0] pend_data;
  logic [MASK_W-1:0] pend_mask;
  logic fill_done, wb_lock, wb_done, fill_way, wb_way, wb_armed;
  logic wb_running, hit0, hit1, fill_req, fill_running, wb_req;
  logic [DATA_W-1:0] o_rdata, o_wdata;
  logic [ADDR_W-1:0] o_faddr;
  logic o_ready;

  port_vals_t expected_q[$];
  int errors = 0;
  int results_seen = 0;

  function automatic logic [10:0] word_idx(logic [ADDR_W-1:0] a);
    return a[12:2];
  endfunction

  function automatic logic [7:0] set_idx(logic [ADDR_W-1:0] a);
    return a[12:5];
  endfunction

  function automatic logic [DATA_W-1:0] lane_merge(logic [DATA_W-1:0] o, logic [DATA_W-1:0] n,
                                                   logic [MASK_W-1:0] m);
    for (int k = 0; k < MASK_W; k++)
      if (m[k]) o[8*k +: 8] = n[8*k +: 8];
    return o;
  endfunction

  task automatic cache_reset();
    for (int i = 0; i < NWORDS; i++) begin
      w0_data[i] = '0;
      w1_data[i] = '0;
    end
    for (int i = 0; i < NSETS; i++) begin
      w0_tag[i] = '0; w1_tag[i] = '0;
      w0_vld[i] = 0; w1_vld[i] = 0; lru[i] = 0;
    end
    held_word[0] = '0; held_word[1] = '0;
    held_tag[0] = '0; held_tag[1] = '0;
    held_vld[0] = 0; held_vld[1] = 0; held_last = 0;
    pend_addr = '0; pend_data = '0; pend_mask = '0; wb_line = '0;
    {fill_done, wb_lock, wb_done, fill_way, wb_way, wb_armed} = '0;
    {wb_running, hit0, hit1, fill_req, fill_running, wb_req} = '0;
    o_rdata = '0; o_wdata = '0; o_faddr = '0; o_ready = 0;
  endtask

  task automatic cache_step(input cyc_t c, output port_vals_t p);
    logic [10:0] cw, bw, pw;
    logic [7:0] cs, bs, ps;
    logic [TAG_W-1:0] ct, bt;
    logic access, hit, busy_fill, busy_wb;
    cw = word_idx(c.ca); cs = set_idx(c.ca); ct = c.ca[27:13];
    bw = word_idx(c.ba); bs = set_idx(c.ba); bt = c.ba[27:13];
    if (pend_mask != 0) begin
      pw = word_idx(pend_addr); ps = set_idx(pend_addr);
      if (hit0) begin
        w0_data[pw] = lane_merge(w0_data[pw], pend_data, pend_mask);
        lru[ps] = 0; wb_armed = 1; wb_line = pend_addr; wb_way = 0;
      end
      if (hit1) begin
        w1_data[pw] = lane_merge(w1_data[pw], pend_data, pend_mask);
        lru[ps] = 1; wb_armed = 1; wb_line = pend_addr; wb_way = 1;
      end
    end
    if (wb_done) wb_done = 0;
    if (wb_armed) begin
      wb_lock = 1;
      if (c.wack) begin
        wb_running = 1; wb_armed = 0;
      end
    end else if (wb_running) begin
      if (c.rstb) o_wdata = wb_way ? w1_data[bw] : w0_data[bw];
      if (c.last) begin
        lru[bs] = wb_way; wb_running = 0; fill_done = 1; wb_lock = 0; wb_done = 1;
      end
    end
    if (fill_req) begin
      if (c.fack) fill_running = 1;
      fill_way = !held_last;
    end else if (fill_running) begin
      if (c.wstb) begin
        if (fill_way) w1_data[bw] = c.fd;
        else w0_data[bw] = c.fd;
      end
      if (c.last) begin
        fill_running = 0; fill_done = 1;
        if (fill_way) begin
          w1_tag[bs] = bt; w1_vld[bs] = 1; lru[bs] = 1; held_tag[1] = bt; held_vld[1] = 1;
        end else begin
          w0_tag[bs] = bt; w0_vld[bs] = 1; lru[bs] = 0; held_tag[0] = bt; held_vld[0] = 1;
        end
      end
    end else begin
      fill_done = 0;
      held_word[0] = w0_data[cw]; held_word[1] = w1_data[cw];
      held_vld[0] = w0_vld[cs]; held_vld[1] = w1_vld[cs];
      held_tag[0] = w0_tag[cs]; held_tag[1] = w1_tag[cs];
      held_last = lru[cs];
    end
    pend_addr = c.ca;
    pend_data = c.wd;
    pend_mask = (pend_mask != 0 || wb_lock) ? '0 : c.bm;
    hit0 = held_vld[0] && held_tag[0] == ct;
    hit1 = held_vld[1] && held_tag[1] == ct;
    hit = hit0 || hit1;
    o_rdata = hit0 ? held_word[0] : (hit1 ? held_word[1] : '0);
    access = c.rd || c.bm != 0;
    busy_fill = !hit || fill_running || fill_done;
    busy_wb = wb_lock && !wb_done;
    o_ready = !(busy_fill || busy_wb) || !access;
    o_faddr = c.ca & 28'hFFFFFE0;
    fill_req = access && !hit && !fill_running;
    wb_req = wb_armed && !wb_running;
    p.rdata = o_rdata; p.ready = o_ready; p.fact = fill_running; p.faddr = o_faddr;
    p.wbaddr = wb_line; p.wbdata = o_wdata; p.freq = fill_req; p.wbreq = wb_req;
  endtask

  // result check
  always @(posedge clk) begin
    port_vals_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item");
      end else begin
        e = expected_q.pop_front();
        if (e.rdata !== cpu_read_data || e.ready !== cpu_ready || e.fact !== fill_active ||
            e.faddr !== fill_addr || e.wbaddr !== writeback_addr ||
            e.wbdata !== writeback_data || e.freq !== fill_request ||
            e.wbreq !== writeback_request) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp rd=%h rdy=%b fa=%b fad=%h wba=%h wbd=%h fr=%b wr=%b",
                     e.rdata, e.ready, e.fact, e.faddr, e.wbaddr, e.wbdata, e.freq, e.wbreq,
                     "\n         got rd=%h rdy=%b fa=%b fad=%h wba=%h wbd=%h fr=%b wr=%b",
                     cpu_read_data, cpu_ready, fill_active, fill_addr, writeback_addr,
                     writeback_data, fill_request, writeback_request);
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int stall_left = 0;
  bit long_done = 0;
  always @(posedge clk) begin
    if (!long_done && results_seen >= 300) begin
      long_done <= 1;
      stall_left <= 400;
      out_stall <= 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if ($urandom_range(0, 9) < 2) begin
      stall_left <= $urandom_range(0, 5);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  function automatic cyc_t directed_row(int i);
    cyc_t c;
    c = '{default: '0};
    case (i)
      0: ;
      1, 2: begin
        c.ca = 28'h0000020; c.rd = 1; c.fack = (i == 2);
      end
      3, 4, 5, 6, 7, 8, 9, 10: begin
        c.ca = 28'h0000020; c.rd = 1; c.wstb = 1;
        c.ba = 28'h0000020 + 28'((i - 3) * 4);
        c.fd = 32'hA5000000 + i; c.last = (i == 10);
      end
      11: begin
        c.ca = 28'h0000024; c.rd = 1;
      end
      12: begin
        c.ca = 28'h0000024; c.bm = 4'hF; c.wd = 32'hFFFFFFFF;
      end
      13: begin
        c.ca = 28'h0000024; c.bm = 4'h5; c.wd = 32'h12345678;
      end
      14: c.wack = 1;
      15, 16, 17, 18: begin
        c.rstb = 1; c.ba = 28'h0000020 + 28'((i - 15) * 4); c.last = (i == 18);
      end
      19: begin
        c.ca = 28'h0000024; c.bm = 4'h1; c.wd = 32'h000000EE;
      end
      20: begin
        c.ca = 28'hFFFFFFF; c.rd = 1;
      end
      default: begin
        c = '{ca: '1, rd: 1, bm: '1, wd: '1, ba: '1, fack: 1, wack: 1, rstb: 1,
              wstb: 1, last: 1, fd: '1};
      end
    endcase
    return c;
  endfunction

  int beat = 0;
  logic [ADDR_W-1:0] burst_line = '0;

  function automatic logic [ADDR_W-1:0] near_addr();
    logic [TAG_W-1:0] t;
    t = ($urandom_range(0, 9) == 0) ? TAG_W'($urandom) : TAG_W'($urandom_range(0, 3));
    return {t, 8'($urandom_range(0, 3)), 3'($urandom), 2'($urandom)};
  endfunction

  task automatic random_row(output cyc_t c);
    c.fd = $urandom;
    c.wd = $urandom;
    if ($urandom_range(0, 99) < 12) begin
      c.ca = ADDR_W'($urandom); c.rd = 1'($urandom); c.bm = MASK_W'($urandom);
      c.ba = ADDR_W'($urandom);
      {c.fack, c.wack, c.rstb, c.wstb, c.last} = 5'($urandom);
      return;
    end
    c.ca = near_addr();
    case ($urandom_range(0, 3))
      0: begin c.rd = 0; c.bm = '0; end
      1: begin c.rd = 0; c.bm = MASK_W'($urandom_range(1, 15)); end
      default: begin c.rd = 1; c.bm = '0; end
    endcase
    {c.fack, c.wack, c.rstb, c.wstb, c.last} = '0;
    c.ba = near_addr();
    if (fill_req && $urandom_range(0, 2) != 0) begin
      c.fack = 1; beat = 0; burst_line = o_faddr;
    end
    if (wb_armed && $urandom_range(0, 2) != 0) begin
      c.wack = 1; beat = 0; burst_line = wb_line & 28'hFFFFFE0;
    end
    if (!c.fack && !c.wack && (fill_running || wb_running) && $urandom_range(0, 4) != 0) begin
      c.ba = burst_line + ADDR_W'(beat * 4);
      c.wstb = fill_running;
      c.rstb = wb_running;
      c.last = (beat == 7);
      beat++;
    end
  endtask

  initial begin
    cyc_t c;
    port_vals_t p;
    int burst_left, total, wait_cycles;
    cache_reset();
    repeat (8) @(posedge clk);
    rst <= 0;
    burst_left = 0;
    total = 22 + N_RANDOM;
    for (int n = 0; n < total; n++) begin
      if (n < 22) c = directed_row(n);
      else random_row(c);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      burst_left--;
      in_valid <= 1;
      cpu_addr <= c.ca; cpu_read <= c.rd; cpu_byte_mask <= c.bm; cpu_write_data <= c.wd;
      bus_addr <= c.ba; bus_fill_ack <= c.fack; bus_writeback_ack <= c.wack;
      bus_read_strobe <= c.rstb; bus_write_strobe <= c.wstb; bus_last_beat <= c.last;
      bus_fill_data <= c.fd;
      do @(posedge clk); while (!(in_valid && !in_stall));
      cache_step(c, p);
      if (n == 0 || n == 1) begin
        p.rdata = '0; p.ready = (n == 0); p.freq = (n == 1);
      end
      expected_q.push_back(p);
    end
    in_valid <= 0;
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
